// ===== sv/adctt_pkg.sv =====
package adctt_pkg;

    // warm-up length and the widths that follow from the field ranges
    localparam int unsigned WARMUP_SAMPLES = 4;
    localparam int unsigned WARMUP_SHIFT   = $clog2(WARMUP_SAMPLES);
    localparam int unsigned CNT_W          = 3;
    localparam int unsigned ADC_W          = 10;
    localparam int unsigned AVG_W          = 12;
    localparam int unsigned OFS_W          = 16;
    localparam int unsigned HALF_W         = OFS_W - 1;
    localparam int unsigned D_W            = 17;
    localparam int unsigned G_W            = 14;
    localparam int unsigned P_W            = D_W + G_W;
    localparam int unsigned MAG_W          = 27;
    localparam int unsigned X_W            = MAG_W - 2;
    localparam int unsigned RECIP_W        = 26;
    localparam int unsigned RECIP_SH       = 30;
    localparam int unsigned QP_W           = X_W + RECIP_W;
    localparam int unsigned Q_W            = QP_W - RECIP_SH;
    localparam int unsigned TEMP_W         = 16;
    localparam int unsigned BYTE_W         = 8;

    // divide by 25 after a shift by two: x / 100 == ((x >> 2) * RECIP) >> shift
    localparam logic [RECIP_W-1:0] RECIP_25   = 26'd42949673;
    localparam logic [14:0]        G_RECIP_25 = 15'd20972;
    localparam int unsigned        G_RECIP_SH = 19;

    // register map, index = paddr[4:2]
    localparam int unsigned APB_AW = 5;
    localparam logic [2:0] REG_CAL_OFFSET    = 3'd0;
    localparam logic [2:0] REG_CAL_GAIN      = 3'd1;
    localparam logic [2:0] REG_CHANGE_ALARM  = 3'd2;
    localparam logic [2:0] REG_PIN_SELECT    = 3'd3;
    localparam logic [2:0] REG_SWITCH_LOW    = 3'd4;
    localparam logic [2:0] REG_SWITCH_HIGH   = 3'd5;
    localparam logic [2:0] REG_ALARM_LOW     = 3'd6;
    localparam logic [2:0] REG_ALARM_HIGH    = 3'd7;

    localparam logic [BYTE_W-1:0] THRESH_OFF     = 8'hFF;
    localparam logic [BYTE_W-1:0] PIN_SEL_LIMIT  = 8'd9;
    localparam logic [BYTE_W-1:0] PIN_DIRECT_MAX = 8'd2;

    typedef struct packed {
        logic signed [OFS_W-1:0] cal_offset;
        logic signed [G_W-1:0]   gain_scale;
        logic                    change_alarm_enable;
        logic [BYTE_W-1:0]       pin_select;
        logic [BYTE_W-1:0]       switch_low;
        logic [BYTE_W-1:0]       switch_high;
        logic [BYTE_W-1:0]       alarm_low;
        logic [BYTE_W-1:0]       alarm_high;
    } t_cfg;

    typedef struct packed {
        logic                  tvalid;
        logic [ADC_W-1:0]      filt;
        logic signed [D_W-1:0] diff;
    } t_filt_beat;

    typedef struct packed {
        logic                  tvalid;
        logic [ADC_W-1:0]      filt;
        logic signed [P_W-1:0] prod;
    } t_prod_beat;

    typedef struct packed {
        logic             tvalid;
        logic [ADC_W-1:0] filt;
        logic             neg;
        logic [Q_W-1:0]   quot;
    } t_quot_beat;

    // trunc(gain / 100) * 16, truncation toward zero
    function automatic logic signed [G_W-1:0] gain_scale(input logic signed [OFS_W-1:0] gain);
        logic [OFS_W-1:0]  mag;
        logic [13:0]       x;
        logic [28:0]       prod;
        logic [8:0]        q;
        logic [G_W-1:0]    g;
        mag  = gain[OFS_W-1] ? OFS_W'(-gain) : OFS_W'(gain);
        x    = mag[OFS_W-1:2];
        prod = x * G_RECIP_25;
        q    = prod[G_RECIP_SH+8:G_RECIP_SH];
        g    = {1'b0, q, 4'b0000};
        return gain[OFS_W-1] ? G_W'(-g) : g;
    endfunction

endpackage

// ===== sv/adctt_cfg.sv =====
module adctt_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [adctt_pkg::APB_AW-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output adctt_pkg::t_cfg                  o_cfg
);

    logic signed [15:0]                  r_cal_offset;
    logic signed [15:0]                  r_cal_gain;
    logic signed [adctt_pkg::G_W-1:0]    r_gain_scale;
    logic                                r_change_alarm;
    logic [7:0]                          r_pin_select;
    logic [7:0]                          r_switch_low;
    logic [7:0]                          r_switch_high;
    logic [7:0]                          r_alarm_low;
    logic [7:0]                          r_alarm_high;
    logic                                wr;
    logic [2:0]                          idx;

    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_offset   <= '0;
            r_cal_gain     <= '0;
            r_gain_scale   <= '0;
            r_change_alarm <= 1'b0;
            r_pin_select   <= 8'd255;
            r_switch_low   <= 8'd255;
            r_switch_high  <= 8'd255;
            r_alarm_low    <= 8'd18;
            r_alarm_high   <= 8'd22;
        end else if (wr) begin
            unique case (idx)
                adctt_pkg::REG_CAL_OFFSET:   r_cal_offset <= pwdata[15:0];
                adctt_pkg::REG_CAL_GAIN: begin
                    r_cal_gain   <= pwdata[15:0];
                    // scale factor is settled at write time
                    r_gain_scale <= adctt_pkg::gain_scale(pwdata[15:0]);
                end
                adctt_pkg::REG_CHANGE_ALARM: r_change_alarm <= pwdata[0];
                adctt_pkg::REG_PIN_SELECT:   r_pin_select   <= pwdata[7:0];
                adctt_pkg::REG_SWITCH_LOW:   r_switch_low   <= pwdata[7:0];
                adctt_pkg::REG_SWITCH_HIGH:  r_switch_high  <= pwdata[7:0];
                adctt_pkg::REG_ALARM_LOW:    r_alarm_low    <= pwdata[7:0];
                adctt_pkg::REG_ALARM_HIGH:   r_alarm_high   <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            adctt_pkg::REG_CAL_OFFSET:   prdata = {16'h0000, r_cal_offset};
            adctt_pkg::REG_CAL_GAIN:     prdata = {16'h0000, r_cal_gain};
            adctt_pkg::REG_CHANGE_ALARM: prdata = {31'h0, r_change_alarm};
            adctt_pkg::REG_PIN_SELECT:   prdata = {24'h0, r_pin_select};
            adctt_pkg::REG_SWITCH_LOW:   prdata = {24'h0, r_switch_low};
            adctt_pkg::REG_SWITCH_HIGH:  prdata = {24'h0, r_switch_high};
            adctt_pkg::REG_ALARM_LOW:    prdata = {24'h0, r_alarm_low};
            adctt_pkg::REG_ALARM_HIGH:   prdata = {24'h0, r_alarm_high};
        endcase
    end

    assign o_cfg.cal_offset          = r_cal_offset;
    assign o_cfg.gain_scale          = r_gain_scale;
    assign o_cfg.change_alarm_enable = r_change_alarm;
    assign o_cfg.pin_select          = r_pin_select;
    assign o_cfg.switch_low          = r_switch_low;
    assign o_cfg.switch_high         = r_switch_high;
    assign o_cfg.alarm_low           = r_alarm_low;
    assign o_cfg.alarm_high          = r_alarm_high;

endmodule

// ===== sv/adctt_filter.sv =====
module adctt_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [adctt_pkg::ADC_W-1:0]       i_sample,
    input  logic signed [adctt_pkg::OFS_W-1:0] i_cal_offset,
    output logic                              o_valid,
    output adctt_pkg::t_filt_beat             o_beat
);

    logic [adctt_pkg::CNT_W-1:0]          r_count;
    logic [adctt_pkg::AVG_W-1:0]          r_avg;
    logic                                 r_valid;
    adctt_pkg::t_filt_beat                r_beat;

    logic [adctt_pkg::CNT_W-1:0]          n_count;
    logic [adctt_pkg::AVG_W-1:0]          n_avg;
    logic [adctt_pkg::AVG_W-1:0]          sum;
    logic [adctt_pkg::AVG_W:0]            blend;
    logic signed [adctt_pkg::HALF_W-1:0]  half;
    adctt_pkg::t_filt_beat                n_beat;
    logic                                 accept;

    assign accept = i_en & i_valid;
    // floor(offset / 2)
    assign half   = i_cal_offset[adctt_pkg::OFS_W-1:1];

    always_comb begin
        sum         = r_avg + adctt_pkg::AVG_W'(i_sample);
        blend       = (adctt_pkg::AVG_W+1)'(r_avg) * (adctt_pkg::AVG_W+1)'(3)
                    + (adctt_pkg::AVG_W+1)'(i_sample);
        n_count     = r_count;
        n_avg       = r_avg;
        n_beat.tvalid = 1'b0;
        n_beat.filt = '0;
        if (r_count < adctt_pkg::CNT_W'(adctt_pkg::WARMUP_SAMPLES)) begin
            n_count = r_count + 1'b1;
            n_avg   = sum;
            if (n_count == adctt_pkg::CNT_W'(adctt_pkg::WARMUP_SAMPLES)) begin
                n_avg       = sum >> adctt_pkg::WARMUP_SHIFT;
                n_beat.filt = n_avg[adctt_pkg::ADC_W-1:0];
            end
        end else begin
            n_avg         = {1'b0, blend[adctt_pkg::AVG_W:2]};
            n_beat.filt   = n_avg[adctt_pkg::ADC_W-1:0];
            n_beat.tvalid = 1'b1;
        end
        // average is within ten bits whenever a temperature is formed
        n_beat.diff = $signed({7'b0, n_avg[adctt_pkg::ADC_W-1:0]})
                    - $signed({{2{half[adctt_pkg::HALF_W-1]}}, half});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_avg   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_en) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_count <= n_count;
                r_avg   <= n_avg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== sv/adctt_scale.sv =====
module adctt_scale (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  adctt_pkg::t_filt_beat             i_beat,
    input  logic signed [adctt_pkg::G_W-1:0]  i_gain_scale,
    output logic                              o_valid,
    output adctt_pkg::t_quot_beat             o_beat
);

    logic                                r_prod_valid;
    adctt_pkg::t_prod_beat               r_prod;
    logic                                r_quot_valid;
    adctt_pkg::t_quot_beat               r_quot;

    logic signed [adctt_pkg::P_W-1:0]    prod;
    logic [adctt_pkg::P_W-1:0]           mag;
    logic [adctt_pkg::X_W-1:0]           x;
    logic [adctt_pkg::QP_W-1:0]          qprod;
    adctt_pkg::t_quot_beat               n_quot;

    // stage one: offset-corrected average times gain scale
    assign prod = i_beat.diff * i_gain_scale;

    // stage two: |prod| / 100 through a reciprocal multiply
    always_comb begin
        mag           = r_prod.prod[adctt_pkg::P_W-1] ? adctt_pkg::P_W'(-r_prod.prod)
                                                      : adctt_pkg::P_W'(r_prod.prod);
        x             = mag[adctt_pkg::MAG_W-1:2];
        qprod         = x * adctt_pkg::RECIP_25;
        n_quot.tvalid = r_prod.tvalid;
        n_quot.filt   = r_prod.filt;
        n_quot.neg    = r_prod.prod[adctt_pkg::P_W-1];
        n_quot.quot   = qprod[adctt_pkg::QP_W-1:adctt_pkg::RECIP_SH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_quot_valid <= 1'b0;
        end else if (i_en) begin
            r_prod_valid <= i_valid;
            r_quot_valid <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod.tvalid <= i_beat.tvalid;
            r_prod.filt   <= i_beat.filt;
            r_prod.prod   <= prod;
            r_quot        <= n_quot;
        end
    end

    assign o_valid = r_quot_valid;
    assign o_beat  = r_quot;

endmodule

// ===== sv/adctt_switch.sv =====
module adctt_switch (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  adctt_pkg::t_quot_beat                i_beat,
    input  adctt_pkg::t_cfg                      i_cfg,
    output logic                                 o_valid,
    output logic signed [adctt_pkg::TEMP_W-1:0]  o_temperature,
    output logic                                 o_temp_valid,
    output logic [adctt_pkg::ADC_W-1:0]          o_filtered_adc,
    output logic                                 o_changed,
    output logic                                 o_alarm,
    output logic [adctt_pkg::BYTE_W-1:0]         o_pin_latch,
    output logic                                 o_pin_written
);

    localparam int unsigned Q_SW = adctt_pkg::Q_W + 1;

    logic signed [adctt_pkg::TEMP_W-1:0]  r_cur_temp;
    logic signed [adctt_pkg::TEMP_W-1:0]  r_last_temp;
    logic [adctt_pkg::BYTE_W-1:0]         r_latch;
    logic                                 r_valid;
    logic                                 r_temp_valid;
    logic [adctt_pkg::ADC_W-1:0]          r_filt;
    logic                                 r_changed;
    logic                                 r_alarm;
    logic                                 r_written;

    logic signed [Q_SW-1:0]               qs;
    logic signed [adctt_pkg::TEMP_W-1:0]  sat1;
    logic signed [adctt_pkg::TEMP_W:0]    minus8;
    logic signed [adctt_pkg::TEMP_W-1:0]  temp_new;
    logic signed [adctt_pkg::TEMP_W-1:0]  cur;
    logic signed [adctt_pkg::TEMP_W-1:0]  last_seed;
    logic [adctt_pkg::BYTE_W-1:0]         deg;
    logic [adctt_pkg::BYTE_W-1:0]         ps_dec;
    logic [adctt_pkg::BYTE_W-1:0]         mask;
    logic [adctt_pkg::BYTE_W-1:0]         n_latch;
    logic                                 chg;
    logic                                 alarm;
    logic                                 written;
    logic                                 accept;

    assign accept = i_en & i_valid;

    always_comb begin
        // sign, saturate, then the optional minus eight
        qs = i_beat.neg ? -$signed({1'b0, i_beat.quot}) : $signed({1'b0, i_beat.quot});
        if (qs > Q_SW'(32767)) begin
            sat1 = 16'sh7FFF;
        end else if (qs < -Q_SW'(32768)) begin
            sat1 = 16'sh8000;
        end else begin
            sat1 = qs[adctt_pkg::TEMP_W-1:0];
        end
        minus8 = $signed({sat1[adctt_pkg::TEMP_W-1], sat1}) - 17'sd8;
        if (!i_cfg.cal_offset[0]) begin
            temp_new = sat1;
        end else if (minus8 < -17'sd32768) begin
            temp_new = 16'sh8000;
        end else begin
            temp_new = minus8[adctt_pkg::TEMP_W-1:0];
        end

        cur       = i_beat.tvalid ? temp_new : r_cur_temp;
        // first nonzero reading only seeds the recorded value
        last_seed = (r_last_temp == '0 && cur != '0) ? cur : r_last_temp;
        chg       = (last_seed != cur);
        deg       = cur[11:4];

        ps_dec = i_cfg.pin_select - 8'd1;
        mask   = (i_cfg.pin_select > adctt_pkg::PIN_DIRECT_MAX)
               ? (8'd1 << ps_dec[2:0]) : i_cfg.pin_select;

        n_latch = r_latch;
        written = 1'b0;
        alarm   = 1'b0;
        if (chg) begin
            alarm = i_cfg.change_alarm_enable;
            if (i_cfg.pin_select < adctt_pkg::PIN_SEL_LIMIT) begin
                if (i_cfg.switch_low != adctt_pkg::THRESH_OFF && deg < i_cfg.switch_low) begin
                    n_latch = n_latch & ~mask;
                    written = 1'b1;
                end
                if (i_cfg.switch_high != adctt_pkg::THRESH_OFF && deg > i_cfg.switch_high) begin
                    n_latch = n_latch | mask;
                    written = 1'b1;
                end
            end
            if (deg < i_cfg.alarm_low || deg > i_cfg.alarm_high) begin
                alarm = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_cur_temp  <= '0;
            r_last_temp <= '0;
            r_latch     <= '0;
        end else begin
            if (i_en) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_cur_temp  <= cur;
                r_last_temp <= cur;
                r_latch     <= n_latch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_temp_valid <= i_beat.tvalid;
            r_filt       <= i_beat.filt;
            r_changed    <= chg;
            r_alarm      <= alarm;
            r_written    <= written;
        end
    end

    assign o_valid        = r_valid;
    assign o_temperature  = r_cur_temp;
    assign o_temp_valid   = r_temp_valid;
    assign o_filtered_adc = r_filt;
    assign o_changed      = r_changed;
    assign o_alarm        = r_alarm;
    assign o_pin_latch    = r_latch;
    assign o_pin_written  = r_written;

endmodule

// ===== sv/adc_thermometer_thermostat.sv =====
// adc thermometer and thermostat: one 10-bit adc sample per input beat gives
// one result beat. the first four samples are summed and averaged; later ones
// blend in as (3*avg + sample) >> 2. from the average a temperature in
// sixteenths of a degree is formed with the calibration offset (halved) and
// gain (hundredths), saturated to 16 bits, minus eight when the offset's low
// bit is set. a change against the last recorded temperature drives the
// change flag, the change alarm, the switch thresholds on the pin latch and
// the alarm window, all on the whole-degree byte. a new sample is taken every
// cycle while o_stall is low; each result goes through the filter register,
// gain product register, divide-by-100 register (reciprocal multiply) and
// output register. a stalled result holds the whole pipeline, so o_stall
// follows i_stall while a result waits. registers are to be written by the
// user over the apb port only while no beat is in flight; unenforced here.
module adc_thermometer_thermostat (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [adctt_pkg::ADC_W-1:0]          i_sample,
    // result channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [adctt_pkg::TEMP_W-1:0]  o_temperature,
    output logic                                 o_temp_valid,
    output logic [adctt_pkg::ADC_W-1:0]          o_filtered_adc,
    output logic                                 o_changed,
    output logic                                 o_alarm,
    output logic [adctt_pkg::BYTE_W-1:0]         o_pin_latch,
    output logic                                 o_pin_written,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [adctt_pkg::APB_AW-1:0]         paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    adctt_pkg::t_cfg        cfg;
    adctt_pkg::t_filt_beat  filt_beat;
    adctt_pkg::t_quot_beat  quot_beat;
    logic                   filt_valid;
    logic                   quot_valid;
    logic                   en;

    // whole pipeline advances unless a finished result is being held
    assign en      = ~(o_valid & i_stall);
    assign o_stall = ~en;

    adctt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // warm-up, running average, offset subtraction
    adctt_filter u_filter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_valid),
        .i_sample     (i_sample),
        .i_cal_offset (cfg.cal_offset),
        .o_valid      (filt_valid),
        .o_beat       (filt_beat)
    );

    // gain product and truncating divide by 100
    adctt_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (filt_valid),
        .i_beat       (filt_beat),
        .i_gain_scale (cfg.gain_scale),
        .o_valid      (quot_valid),
        .o_beat       (quot_beat)
    );

    // saturation, change detection, thresholds, output register
    adctt_switch u_switch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (quot_valid),
        .i_beat         (quot_beat),
        .i_cfg          (cfg),
        .o_valid        (o_valid),
        .o_temperature  (o_temperature),
        .o_temp_valid   (o_temp_valid),
        .o_filtered_adc (o_filtered_adc),
        .o_changed      (o_changed),
        .o_alarm        (o_alarm),
        .o_pin_latch    (o_pin_latch),
        .o_pin_written  (o_pin_written)
    );

endmodule

// ===== sv/adctt_checker.sv =====
module adctt_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic signed [adctt_pkg::TEMP_W-1:0]  o_temperature,
    input logic                                 o_changed,
    input logic                                 o_alarm,
    input logic [adctt_pkg::BYTE_W-1:0]         o_pin_latch,
    input logic                                 o_pin_written
);

    // a held result beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_temperature)
            && $stable(o_pin_latch) && $stable(o_alarm))
        else $error("held result beat changed");

    // alarms come only with a temperature change
    a_alarm_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_alarm |-> o_changed)
        else $error("alarm without change");

    // pins are switched only on a change
    a_write_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pin_written |-> o_changed)
        else $error("pin write without change");

    // the sample side is held back only by a waiting result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

endmodule

bind adc_thermometer_thermostat adctt_checker u_adctt_checker (.*);

// ===== sim/adc_thermometer_thermostat_tb.sv =====
`timescale 1ns / 100ps

typedef struct packed {
    logic signed [adctt_pkg::TEMP_W-1:0] temperature;
    logic                                temp_valid;
    logic [adctt_pkg::ADC_W-1:0]         filtered_adc;
    logic                                changed;
    logic                                alarm;
    logic [adctt_pkg::BYTE_W-1:0]        pin_latch;
    logic                                pin_written;
} t_reading;

class t_thermostat_tracker;
    // calibration and thermostat settings
    logic signed [adctt_pkg::OFS_W-1:0] cal_offset = '0;
    logic signed [adctt_pkg::OFS_W-1:0] cal_gain = '0;
    logic                               change_alarm_en = 1'b0;
    logic [adctt_pkg::BYTE_W-1:0]       pin_select = 8'd255;
    logic [adctt_pkg::BYTE_W-1:0]       switch_low = 8'd255;
    logic [adctt_pkg::BYTE_W-1:0]       switch_high = 8'd255;
    logic [adctt_pkg::BYTE_W-1:0]       alarm_low = 8'd18;
    logic [adctt_pkg::BYTE_W-1:0]       alarm_high = 8'd22;
    // filter and thermostat state
    logic [adctt_pkg::CNT_W-1:0]        warm_count = '0;
    logic [adctt_pkg::AVG_W-1:0]        adc_avg = '0;
    logic [adctt_pkg::TEMP_W-1:0]       cur_temp = '0;
    logic [adctt_pkg::TEMP_W-1:0]       recorded_temp = '0;
    logic [adctt_pkg::BYTE_W-1:0]       pins = '0;

    t_reading                           pending_readings[$];
    int                                 errors = 0;

    function void set_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            adctt_pkg::REG_CAL_OFFSET:   cal_offset = v[15:0];
            adctt_pkg::REG_CAL_GAIN:     cal_gain = v[15:0];
            adctt_pkg::REG_CHANGE_ALARM: change_alarm_en = v[0];
            adctt_pkg::REG_PIN_SELECT:   pin_select = v[7:0];
            adctt_pkg::REG_SWITCH_LOW:   switch_low = v[7:0];
            adctt_pkg::REG_SWITCH_HIGH:  switch_high = v[7:0];
            adctt_pkg::REG_ALARM_LOW:    alarm_low = v[7:0];
            adctt_pkg::REG_ALARM_HIGH:   alarm_high = v[7:0];
            default: ;
        endcase
    endfunction

    function int clip16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // (avg - floor(offset/2)) * trunc(gain/100)*16 / 100, minus eight on odd offset
    function logic [adctt_pkg::TEMP_W-1:0] scaled_temp();
        int off, lowbit, half, g, d, q;
        off = cal_offset;
        lowbit = cal_offset[0];
        half = (off - lowbit) / 2;
        g = cal_gain;
        g = (g / 100) * 16;
        d = adc_avg;
        d = d - half;
        q = clip16((d * g) / 100);
        if (lowbit != 0)
            q = clip16(q - 8);
        return q[adctt_pkg::TEMP_W-1:0];
    endfunction

    function void take_sample(logic [adctt_pkg::ADC_W-1:0] s);
        t_reading                     r;
        logic [adctt_pkg::BYTE_W-1:0] deg, mask;
        int                           acc;
        r = '0;
        if (warm_count < adctt_pkg::WARMUP_SAMPLES) begin
            adc_avg = adc_avg + s;
            warm_count = warm_count + 1'b1;
            if (warm_count == adctt_pkg::WARMUP_SAMPLES) begin
                adc_avg = adctt_pkg::AVG_W'(adc_avg / adctt_pkg::WARMUP_SAMPLES);
                r.filtered_adc = adc_avg[adctt_pkg::ADC_W-1:0];
            end
        end else begin
            acc = adc_avg;
            acc = (acc * 3 + s) >> 2;
            adc_avg = acc[adctt_pkg::AVG_W-1:0];
            r.filtered_adc = adc_avg[adctt_pkg::ADC_W-1:0];
            cur_temp = scaled_temp();
            r.temp_valid = 1'b1;
        end
        // first nonzero reading only seeds the recorded value
        if (recorded_temp == '0 && cur_temp != '0)
            recorded_temp = cur_temp;
        if (recorded_temp != cur_temp) begin
            deg = cur_temp[11:4];
            r.changed = 1'b1;
            if (change_alarm_en)
                r.alarm = 1'b1;
            recorded_temp = cur_temp;
            if (pin_select < adctt_pkg::PIN_SEL_LIMIT) begin
                mask = pin_select;
                if (mask > adctt_pkg::PIN_DIRECT_MAX)
                    mask = 8'(1 << (mask - 1));
                if (switch_low != adctt_pkg::THRESH_OFF && deg < switch_low) begin
                    pins = pins & ~mask;
                    r.pin_written = 1'b1;
                end
                if (switch_high != adctt_pkg::THRESH_OFF && deg > switch_high) begin
                    pins = pins | mask;
                    r.pin_written = 1'b1;
                end
            end
            if (deg < alarm_low || deg > alarm_high)
                r.alarm = 1'b1;
        end
        r.temperature = cur_temp;
        r.pin_latch = pins;
        pending_readings.push_back(r);
    endfunction

    function void match_reading(t_reading got);
        t_reading want;
        if (pending_readings.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected reading: temp %0d adc %0d", got.temperature,
                         got.filtered_adc);
            return;
        end
        want = pending_readings.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch exp: temp %0d vld %0b adc %0d chg %0b alm %0b pins %02h wr %0b",
                         want.temperature, want.temp_valid, want.filtered_adc, want.changed,
                         want.alarm, want.pin_latch, want.pin_written);
                $display("         got: temp %0d vld %0b adc %0d chg %0b alm %0b pins %02h wr %0b",
                         got.temperature, got.temp_valid, got.filtered_adc, got.changed,
                         got.alarm, got.pin_latch, got.pin_written);
            end
        end
    endfunction

    function int pending();
        return pending_readings.size();
    endfunction
endclass

module adc_thermometer_thermostat_tb;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    // sample side
    logic                                 i_valid = 1'b0;
    logic                                 o_stall;
    logic [adctt_pkg::ADC_W-1:0]          i_sample = '0;
    // result side
    logic                                 o_valid;
    logic                                 i_stall = 1'b0;
    logic signed [adctt_pkg::TEMP_W-1:0]  o_temperature;
    logic                                 o_temp_valid;
    logic [adctt_pkg::ADC_W-1:0]          o_filtered_adc;
    logic                                 o_changed;
    logic                                 o_alarm;
    logic [adctt_pkg::BYTE_W-1:0]         o_pin_latch;
    logic                                 o_pin_written;
    // register port
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [adctt_pkg::APB_AW-1:0]         paddr = '0;
    logic [31:0]                          pwdata = '0;
    logic [31:0]                          prdata;
    logic                                 pready;

    // no idling on either side while set
    bit                                   calm = 1'b0;

    t_thermostat_tracker                  tracker = new();

    adc_thermometer_thermostat dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_temperature  (o_temperature),
        .o_temp_valid   (o_temp_valid),
        .o_filtered_adc (o_filtered_adc),
        .o_changed      (o_changed),
        .o_alarm        (o_alarm),
        .o_pin_latch    (o_pin_latch),
        .o_pin_written  (o_pin_written),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 i_clk = ~i_clk;

    // result-side back pressure, about a quarter of the cycles
    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 24);
    end

    // watch both channels; a sample beat is booked before the result beat
    // of the same edge is checked
    always @(posedge i_clk) begin
        t_reading got;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                tracker.take_sample(i_sample);
            if (o_valid && !i_stall) begin
                got.temperature = o_temperature;
                got.temp_valid = o_temp_valid;
                got.filtered_adc = o_filtered_adc;
                got.changed = o_changed;
                got.alarm = o_alarm;
                got.pin_latch = o_pin_latch;
                got.pin_written = o_pin_written;
                tracker.match_reading(got);
            end
        end
    end

    // present one sample beat and hold it until it is taken, with random
    // idle cycles in front of it
    task automatic send_sample(input logic [adctt_pkg::ADC_W-1:0] s);
        while (!calm && $urandom_range(0, 99) < 24) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_stall);
    endtask

    // stop sending and wait for every result beat plus the pipeline depth
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // setup cycle then access cycle; psel stays up for back-to-back writes
    task automatic program_reg(input logic [2:0] idx, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, v);
    endtask

    task automatic configure(input logic [15:0] ofs, input logic [15:0] gain,
                             input logic ena, input logic [7:0] sel,
                             input logic [7:0] sw_lo, input logic [7:0] sw_hi,
                             input logic [7:0] al_lo, input logic [7:0] al_hi);
        settle();
        program_reg(adctt_pkg::REG_CAL_OFFSET, {16'd0, ofs});
        program_reg(adctt_pkg::REG_CAL_GAIN, {16'd0, gain});
        program_reg(adctt_pkg::REG_CHANGE_ALARM, {31'd0, ena});
        program_reg(adctt_pkg::REG_PIN_SELECT, {24'd0, sel});
        program_reg(adctt_pkg::REG_SWITCH_LOW, {24'd0, sw_lo});
        program_reg(adctt_pkg::REG_SWITCH_HIGH, {24'd0, sw_hi});
        program_reg(adctt_pkg::REG_ALARM_LOW, {24'd0, al_lo});
        program_reg(adctt_pkg::REG_ALARM_HIGH, {24'd0, al_hi});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // mostly a gain from 200 to 2500 and an offset within +-200, now and then anything
    task automatic random_setup();
        logic [15:0] ofs, gain;
        logic [7:0]  sel, sw_lo, sw_hi, al_lo, al_hi;
        if ($urandom_range(0, 9) == 0) begin
            ofs = 16'($urandom);
            gain = 16'($urandom);
        end else begin
            ofs = 16'($urandom_range(0, 400) - 200);
            gain = 16'($urandom_range(200, 2500));
            if ($urandom_range(0, 9) == 0)
                gain = -gain;
        end
        sel = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 10));
        sw_lo = ($urandom_range(0, 5) == 0) ? adctt_pkg::THRESH_OFF
                                            : 8'($urandom_range(0, 110));
        sw_hi = ($urandom_range(0, 5) == 0) ? adctt_pkg::THRESH_OFF
                                            : 8'($urandom_range(0, 110));
        if ($urandom_range(0, 7) == 0) begin
            al_lo = 8'($urandom);
            al_hi = 8'($urandom);
        end else begin
            al_lo = 8'($urandom_range(0, 80));
            al_hi = al_lo + 8'($urandom_range(0, 60));
        end
        configure(ofs, gain, 1'($urandom_range(0, 1)), sel, sw_lo, sw_hi, al_lo, al_hi);
    endtask

    initial begin
        int level, s, pick;
        level = 512;
        s = 512;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // warm-up at full scale (sum fills all twelve bits), then zero gain
        send_sample(10'd1023);
        send_sample(10'd1023);
        send_sample(10'd1023);
        send_sample(10'd1023);
        send_sample(10'd0);

        // seeding, then falling through the switch thresholds to a steady value
        configure(16'd0, 16'd1000, 1'b1, 8'd1, 8'd40, 8'd60, 8'd18, 8'd22);
        send_sample(10'd512);
        send_sample(10'd0);
        send_sample(10'd0);
        send_sample(10'd0);
        send_sample(10'd0);
        send_sample(10'd222);

        // positive saturation at the extreme offset and gain, then held
        configure(16'h8000, 16'h7fff, 1'b0, 8'd2, 8'd255, 8'd255, 8'd0, 8'd255);
        send_sample(10'd1023);
        send_sample(10'd1023);

        // saturation with the minus-eight step on an odd offset, negative gain
        configure(16'h7fff, 16'h8000, 1'b0, 8'd8, 8'd255, 8'd0, 8'd0, 8'd0);
        send_sample(10'd0);
        send_sample(10'd1023);

        // negative saturation, switching disabled by pin number
        configure(16'h8000, 16'h8000, 1'b1, 8'd9, 8'd0, 8'd0, 8'd0, 8'd0);
        send_sample(10'd700);
        send_sample(10'd300);

        // gain below one hundred: only the minus eight is left, empty pin mask
        configure(16'hfffd, 16'd99, 1'b0, 8'd0, 8'd200, 8'd100, 8'd50, 8'd60);
        send_sample(10'd500);
        send_sample(10'd500);

        // back to zero degrees counts as a change, the next one does not
        configure(16'd0, 16'd0, 1'b0, 8'd3, 8'd255, 8'd255, 8'd18, 8'd22);
        send_sample(10'd100);
        send_sample(10'd900);

        // random phases: a slow random walk with holds and jumps
        for (int ph = 0; ph < 15; ph++) begin
            random_setup();
            calm = (ph == 7);
            for (int n = 0; n < 110; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    s = $urandom_range(0, 1023);
                    level = s;
                end else if (pick >= 40) begin
                    level = level + $urandom_range(0, 24) - 12;
                    if (level < 0)
                        level = 0;
                    if (level > 1023)
                        level = 1023;
                    s = level;
                end
                send_sample(10'(s));
            end
        end
        calm = 1'b0;

        settle();
        if (tracker.errors + tracker.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
